// ----- hw/rtl/blpc_pkg.sv -----
// Shared types, codes and time helpers for the bicolor LED blink and pulse controller.
`default_nettype none

package blpc_pkg;

    localparam int TIME_BITS = 16;

    typedef logic [TIME_BITS-1:0] t_time;

    localparam t_time TIME_MAX = '1;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_STATIC = 3'd1,
        ACT_BLINK  = 3'd2,
        ACT_PULSE  = 3'd3,
        ACT_PUSH   = 3'd4,
        ACT_POP    = 3'd5
    } t_action;

    typedef struct packed {
        logic        accepted;
        logic        busy_res;
        logic        blinking;
        logic [15:0] current_color;
        logic [7:0]  green_duty;
        logic [7:0]  red_duty;
    } t_result;

    // Saturate a 16-bit time to the timer range, zero acts as one.
    function automatic t_time clamp_time(logic [15:0] v);
        logic [32:0] wide;
        t_time       t;
        wide = 33'(v);
        if (wide > 33'(TIME_MAX)) begin
            t = TIME_MAX;
        end else begin
            t = t_time'(v);
        end
        if (t == '0) begin
            t = t_time'(1);
        end
        return t;
    endfunction

    // Stored times are already in range: only map zero to one.
    function automatic t_time nonzero_time(t_time v);
        return (v == '0) ? t_time'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bicolor_led_blink_pulse_controller.sv -----
// Top level of the bicolor LED blink and pulse controller.
//
// Input channel s_axis: one item per command or per 1 ms tick. tuser carries
// the action code, tdata the color, pulse flag, duration and period.
// Output channel m_axis: exactly one result item per input item, in order,
// with the LED duties, current color, blink flag, busy flag and accept flag.
// With the result queue empty, the result is valid in the cycle after its
// item is accepted; results already waiting ahead of it are sent first.
// Throughput: one item per cycle while s_axis_tready is high; the command
// decode and state update are combinational against the state registers.
// A two-entry result queue sits between the state update and m_axis, so an
// item is taken while an earlier result still waits; s_axis_tready drops
// whenever both queue entries are full, whatever m_axis_tready does.
// Commands other than tick and pop are rejected (accepted = 0) while a pulse
// or push holds the controller; the state is then left as it was.
// Reset (i_rst_n low, synchronous) empties the queue and sets the LED to
// static color 0xFFFF with no pulse or push held.
`default_nettype none

module bicolor_led_blink_pulse_controller
    import blpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] color, [16] pulse_blinks, [32:17] duration, [48:33] period
    input  wire logic [55:0] s_axis_tdata,
    // [2:0] action
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] red_duty, [15:8] green_duty, [31:16] current_color, [32] blinking,
    // [33] busy_res, [34] accepted
    output logic [39:0]      m_axis_tdata
);

    logic    in_accept;
    t_result result;
    t_result head;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    blpc_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_action       (s_axis_tuser),
        .i_color        (s_axis_tdata[15:0]),
        .i_pulse_blinks (s_axis_tdata[16]),
        .i_duration     (s_axis_tdata[32:17]),
        .i_period       (s_axis_tdata[48:33]),
        .o_result       (result)
    );

    blpc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (result),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = {5'b0, head.accepted, head.busy_res, head.blinking,
                           head.current_color, head.green_duty, head.red_duty};

endmodule

`default_nettype wire

// ----- hw/rtl/blpc_engine.sv -----
// Command decode and LED state registers: one accepted item per cycle, result formed combinationally.
`default_nettype none

module blpc_engine
    import blpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_color,
    input  wire logic        i_pulse_blinks,
    input  wire logic [15:0] i_duration,
    input  wire logic [15:0] i_period,
    output t_result          o_result
);

    typedef struct packed {
        logic [15:0] cur_color;
        logic        cur_blink;
        logic        lit_phase;
        t_time       cur_period;
        t_time       blink_count;
        logic [15:0] saved_color;
        logic        saved_blink;
        t_time       saved_period;
        t_time       pulse_count;
        logic        pulse_active;
        logic        push_held;
    } t_state;

    localparam t_state STATE_RESET = '{
        cur_color:    16'hFFFF,
        cur_blink:    1'b0,
        lit_phase:    1'b0,
        cur_period:   '0,
        blink_count:  '0,
        saved_color:  16'h0000,
        saved_blink:  1'b0,
        saved_period: '0,
        pulse_count:  '0,
        pulse_active: 1'b0,
        push_held:    1'b0
    };

    t_state r_state;
    t_state n_state;
    logic   accepted;
    logic   lit;
    t_time  tick_count;

    function automatic t_state show_static(t_state s, logic [15:0] c);
        t_state o;
        o             = s;
        o.cur_color   = c;
        o.cur_blink   = 1'b0;
        o.lit_phase   = 1'b0;
        o.blink_count = '0;
        return o;
    endfunction

    function automatic t_state show_blink(t_state s, logic [15:0] c, t_time p);
        t_state o;
        o             = s;
        o.cur_color   = c;
        o.cur_blink   = 1'b1;
        o.lit_phase   = 1'b1;
        o.cur_period  = p;
        o.blink_count = '0;
        return o;
    endfunction

    function automatic t_state save_setting(t_state s);
        t_state o;
        o              = s;
        o.saved_color  = s.cur_color;
        o.saved_blink  = s.cur_blink;
        o.saved_period = s.cur_period;
        return o;
    endfunction

    function automatic t_state restore_setting(t_state s);
        t_state o;
        if (s.saved_blink) begin
            o = show_blink(s, s.saved_color, nonzero_time(s.saved_period));
        end else begin
            o = show_static(s, s.saved_color);
        end
        return o;
    endfunction

    always_comb begin
        n_state    = r_state;
        accepted   = 1'b1;
        tick_count = r_state.blink_count + t_time'(1);
        unique case (t_action'(i_action))
            ACT_TICK: begin
                if (r_state.cur_blink) begin
                    if (tick_count >= nonzero_time(r_state.cur_period)) begin
                        n_state.lit_phase   = ~r_state.lit_phase;
                        n_state.blink_count = '0;
                    end else begin
                        n_state.blink_count = tick_count;
                    end
                end
                // A pulse ending on this tick overrides the blink advance.
                if (r_state.pulse_active) begin
                    if (r_state.pulse_count <= t_time'(1)) begin
                        n_state.pulse_count  = '0;
                        n_state.pulse_active = 1'b0;
                        n_state              = restore_setting(n_state);
                    end else begin
                        n_state.pulse_count = r_state.pulse_count - t_time'(1);
                    end
                end
            end
            ACT_POP: begin
                if (r_state.push_held) begin
                    n_state           = restore_setting(r_state);
                    n_state.push_held = 1'b0;
                end else begin
                    accepted = 1'b0;
                end
            end
            ACT_STATIC, ACT_BLINK, ACT_PULSE, ACT_PUSH: begin
                if (r_state.pulse_active || r_state.push_held) begin
                    accepted = 1'b0;
                end else if (t_action'(i_action) == ACT_STATIC) begin
                    n_state = show_static(r_state, i_color);
                end else if (t_action'(i_action) == ACT_BLINK) begin
                    n_state = show_blink(r_state, i_color, clamp_time(i_period));
                end else if (t_action'(i_action) == ACT_PULSE) begin
                    n_state = save_setting(r_state);
                    if (i_pulse_blinks) begin
                        n_state = show_blink(n_state, i_color, clamp_time(i_period));
                    end else begin
                        n_state = show_static(n_state, i_color);
                    end
                    n_state.pulse_count  = clamp_time(i_duration);
                    n_state.pulse_active = 1'b1;
                end else begin
                    n_state           = show_static(save_setting(r_state), i_color);
                    n_state.push_held = 1'b1;
                end
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    always_comb begin
        lit                    = !n_state.cur_blink || n_state.lit_phase;
        o_result.red_duty      = lit ? n_state.cur_color[15:8] : 8'h00;
        o_result.green_duty    = lit ? n_state.cur_color[7:0] : 8'h00;
        o_result.current_color = n_state.cur_color;
        o_result.blinking      = n_state.cur_blink;
        o_result.busy_res      = n_state.pulse_active || n_state.push_held;
        o_result.accepted      = accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blpc_out_fifo.sv -----
// Two-entry result queue that decouples the input side from output stalls.
`default_nettype none

module blpc_out_fifo
    import blpc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_pop,
    output t_result      o_data
);

    t_result    r_data [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       take;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rptr];
    assign take    = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (take) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !take) begin
                r_count <= r_count + 2'd1;
            end else if (take && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/blpc_checker.sv -----
// Port-level checks for the bicolor LED controller, bound to the top level.
`default_nettype none

module blpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);

    // Hold a stalled result item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Duties are either dark or the bytes of the current color.
    a_duty_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[15:0] == 16'h0000) ||
            ({m_axis_tdata[7:0], m_axis_tdata[15:8]} == m_axis_tdata[31:16]))
        else $error("duties do not match current color");

    a_static_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[32] |->
            {m_axis_tdata[7:0], m_axis_tdata[15:8]} == m_axis_tdata[31:16])
        else $error("static mode shows dark or wrong duties");

    // An item accepted into an empty queue shows up on the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
        else $error("result missing one cycle after item");

endmodule

bind bicolor_led_blink_pulse_controller blpc_checker u_blpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking stream testbench for the bicolor LED blink and pulse controller.
module testbench;
    import blpc_pkg::*;

    localparam logic [2:0] ACT_UNDEF_A = 3'd6;
    localparam logic [2:0] ACT_UNDEF_B = 3'd7;

    typedef struct {
        logic [2:0]  act;
        logic [15:0] color;
        logic        blinks;
        logic [15:0] duration;
        logic [15:0] period;
        bit          drain;
    } t_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] color, [16] pulse_blinks, [32:17] duration, [48:33] period
    logic [55:0] s_axis_tdata = '0;
    // [2:0] action
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] red_duty, [15:8] green_duty, [31:16] current_color, [32] blinking,
    // [33] busy_res, [34] accepted
    logic [39:0] m_axis_tdata;

    bicolor_led_blink_pulse_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Predicted controller state
    logic [15:0] led_color = 16'hFFFF;
    logic        led_blink = 1'b0;
    logic        led_lit = 1'b0;
    t_time       led_period = '0;
    t_time       blink_ticks = '0;
    logic [15:0] save_color = '0;
    logic        save_blink = 1'b0;
    t_time       save_period = '0;
    t_time       pulse_left = '0;
    logic        pulse_on = 1'b0;
    logic        push_on = 1'b0;

    t_cmd    cmd_q[$];
    t_result led_expect_q[$];
    t_cmd    sent_cmd;
    t_result pred;
    t_result want;
    t_result got;
    int      gap_left = 0;
    int      stall_left = 0;
    bit      tx_calm = 0;
    bit      rx_calm = 0;
    int      n_queued = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      n_rejected = 0;
    int      n_restores = 0;
    int      n_toggles = 0;
    int      n_err = 0;

    function automatic t_time at_least_one(logic [15:0] v);
        if (v > TIME_MAX) return TIME_MAX;
        return (v == '0) ? t_time'(1) : t_time'(v);
    endfunction

    task automatic show_steady(logic [15:0] c);
        led_color = c;
        led_blink = 1'b0;
        led_lit = 1'b0;
        blink_ticks = '0;
    endtask

    task automatic show_flashing(logic [15:0] c, logic [15:0] p);
        led_color = c;
        led_blink = 1'b1;
        led_lit = 1'b1;
        led_period = at_least_one(p);
        blink_ticks = '0;
    endtask

    task automatic save_current();
        save_color = led_color;
        save_blink = led_blink;
        save_period = led_period;
    endtask

    task automatic restore_saved();
        if (save_blink) show_flashing(save_color, save_period);
        else show_steady(save_color);
    endtask

    task automatic led_predict(input t_cmd c, output t_result r);
        logic held;
        logic ok;
        logic shown;
        held = pulse_on | push_on;
        ok = 1'b1;
        case (c.act)
            ACT_TICK: begin
                // blink advances first, a pulse ending on the same tick wins
                if (led_blink) begin
                    blink_ticks = blink_ticks + 1'b1;
                    if (blink_ticks >= at_least_one(led_period)) begin
                        led_lit = ~led_lit;
                        blink_ticks = '0;
                        n_toggles++;
                    end
                end
                if (pulse_on) begin
                    if (pulse_left <= 1) begin
                        pulse_left = '0;
                        pulse_on = 1'b0;
                        restore_saved();
                        n_restores++;
                    end else begin
                        pulse_left = pulse_left - 1'b1;
                    end
                end
            end
            ACT_POP: begin
                if (push_on) begin
                    restore_saved();
                    push_on = 1'b0;
                    n_restores++;
                end else begin
                    ok = 1'b0;
                end
            end
            ACT_STATIC: begin
                if (held) ok = 1'b0;
                else show_steady(c.color);
            end
            ACT_BLINK: begin
                if (held) ok = 1'b0;
                else show_flashing(c.color, c.period);
            end
            ACT_PULSE: begin
                if (held) begin
                    ok = 1'b0;
                end else begin
                    save_current();
                    if (c.blinks) show_flashing(c.color, c.period);
                    else show_steady(c.color);
                    pulse_left = at_least_one(c.duration);
                    pulse_on = 1'b1;
                end
            end
            ACT_PUSH: begin
                if (held) begin
                    ok = 1'b0;
                end else begin
                    save_current();
                    show_steady(c.color);
                    push_on = 1'b1;
                end
            end
            default: ok = 1'b0;
        endcase
        shown = !led_blink || led_lit;
        r.red_duty = shown ? led_color[15:8] : 8'h00;
        r.green_duty = shown ? led_color[7:0] : 8'h00;
        r.current_color = led_color;
        r.blinking = led_blink;
        r.busy_res = pulse_on | push_on;
        r.accepted = ok;
        if (!ok) n_rejected++;
    endtask

    task automatic report_mismatch(string field, logic [31:0] seen, logic [31:0] expected);
        if (n_err < 40)
            $display("[%0t] mismatch on %s: got %h, want %h", $time, field, seen, expected);
        n_err++;
    endtask

    // Mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                led_predict(sent_cmd, pred);
                led_expect_q.push_back(pred);
                n_sent++;
                gap_left = pick_gap(tx_calm);
                if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
            end
            // hold the item while it waits for tready
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (cmd_q.size() != 0 && cmd_q[0].drain) begin
                    s_axis_tvalid <= 1'b0;
                    if (led_expect_q.size() == 0) void'(cmd_q.pop_front());
                end else if (cmd_q.size() != 0) begin
                    sent_cmd = cmd_q.pop_front();
                    s_axis_tdata <= {7'b0, sent_cmd.period, sent_cmd.duration,
                                     sent_cmd.blinks, sent_cmd.color};
                    s_axis_tuser <= sent_cmd.act;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[34:0]);
                if (led_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
                end else begin
                    want = led_expect_q.pop_front();
                    n_checked++;
                    if (got.red_duty !== want.red_duty)
                        report_mismatch("red_duty", 32'(got.red_duty), 32'(want.red_duty));
                    if (got.green_duty !== want.green_duty)
                        report_mismatch("green_duty", 32'(got.green_duty),
                                        32'(want.green_duty));
                    if (got.current_color !== want.current_color)
                        report_mismatch("current_color", 32'(got.current_color),
                                        32'(want.current_color));
                    if (got.blinking !== want.blinking)
                        report_mismatch("blinking", 32'(got.blinking), 32'(want.blinking));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
                end
            end
            if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(rx_calm) : 0;
                m_axis_tready <= (stall_left == 0);
            end
        end
    end

    task automatic add_cmd(logic [2:0] act, logic [15:0] color, logic blinks,
                           logic [15:0] duration, logic [15:0] period, bit counted);
        t_cmd c;
        c.act = act;
        c.color = color;
        c.blinks = blinks;
        c.duration = duration;
        c.period = period;
        c.drain = 0;
        cmd_q.push_back(c);
        if (counted) n_queued++;
    endtask

    task automatic add_ticks(int n);
        repeat (n) add_cmd(ACT_TICK, 16'($urandom), 1'($urandom), 16'($urandom),
                           16'($urandom), 1);
    endtask

    // Pause the sender until every expected result is back
    task automatic add_drain();
        t_cmd c;
        c = '{default: '0};
        c.drain = 1;
        cmd_q.push_back(c);
    endtask

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'hFF00;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom_range(0, 3));
        if (r < 9) return 16'($urandom_range(4, 12));
        return 16'($urandom);
    endfunction

    function automatic logic [2:0] pick_blocked();
        return 3'($urandom_range(ACT_STATIC, ACT_POP));
    endfunction

    initial begin
        int next_drain;
        int dur;
        int ticks;
        logic [2:0] act;

        // directed: reset state, modes, zero period, pulse ends, push/pop, bad codes
        add_ticks(1);
        add_cmd(ACT_STATIC, 16'h0000, 1'b0, 16'hFFFF, 16'hFFFF, 1);
        add_cmd(ACT_STATIC, 16'h00FF, 1'b1, 16'h0000, 16'h0000, 1);
        add_cmd(ACT_BLINK, 16'hA55A, 1'b0, 16'h0000, 16'h0000, 1);
        add_ticks(2);
        add_cmd(ACT_BLINK, 16'h5AA5, 1'b0, 16'h0000, 16'd2, 1);
        add_ticks(2);
        add_cmd(ACT_PULSE, 16'h1234, 1'b0, 16'h0000, 16'h0000, 1);
        add_cmd(ACT_STATIC, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1);
        add_cmd(ACT_POP, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1);
        add_ticks(1);
        add_cmd(ACT_PULSE, 16'hFF00, 1'b1, 16'd2, 16'h0000, 1);
        add_ticks(2);
        add_cmd(ACT_PUSH, 16'h00FF, 1'b0, 16'h0000, 16'h0000, 1);
        add_cmd(ACT_BLINK, 16'h0F0F, 1'b0, 16'h0000, 16'd3, 1);
        add_cmd(ACT_PUSH, 16'hF0F0, 1'b0, 16'h0000, 16'h0000, 1);
        add_ticks(1);
        add_cmd(ACT_POP, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1);
        add_cmd(ACT_POP, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1);
        add_cmd(ACT_UNDEF_A, 16'h1111, 1'b0, 16'h0001, 16'h0001, 1);
        add_cmd(ACT_UNDEF_B, 16'h2222, 1'b1, 16'h0002, 16'h0002, 1);
        add_cmd(ACT_BLINK, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1);
        add_drain();

        next_drain = 200;
        while (n_queued < 600) begin
            if (n_queued >= next_drain) begin
                add_drain();
                next_drain += 200;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    act = $urandom_range(0, 1) ? ACT_STATIC : ACT_BLINK;
                    add_cmd(act, pick_color(), 1'($urandom), 16'($urandom),
                            pick_period(), 1);
                    add_ticks($urandom_range(0, 8));
                end
                3, 4, 5: begin
                    dur = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5)
                                                     : $urandom_range(6, 30);
                    add_cmd(ACT_PULSE, pick_color(), 1'($urandom), 16'(dur),
                            pick_period(), 1);
                    ticks = 0;
                    while (ticks <= dur + 1) begin
                        if ($urandom_range(0, 3) == 0) begin
                            add_cmd(pick_blocked(), 16'($urandom), 1'($urandom),
                                    16'($urandom), 16'($urandom), 1);
                        end else begin
                            add_ticks(1);
                            ticks++;
                        end
                    end
                end
                6, 7: begin
                    add_cmd(ACT_PUSH, pick_color(), 1'($urandom), 16'($urandom),
                            16'($urandom), 1);
                    repeat ($urandom_range(0, 5)) begin
                        if ($urandom_range(0, 1)) add_ticks(1);
                        else add_cmd(pick_blocked(), 16'($urandom), 1'($urandom),
                                     16'($urandom), 16'($urandom), 1);
                    end
                    add_cmd(ACT_POP, 16'($urandom), 1'($urandom), 16'($urandom),
                            16'($urandom), 1);
                    add_ticks($urandom_range(0, 3));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        add_cmd(3'($urandom_range(ACT_TICK, ACT_UNDEF_B)), 16'($urandom),
                                1'($urandom), 16'($urandom), 16'($urandom), 0);
                end
            endcase
        end

        // longest pulse last, it holds the controller to the end
        add_cmd(ACT_PULSE, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1);
        add_cmd(ACT_STATIC, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1);
        add_ticks(3);

        while (cmd_q.size() != 0 || s_axis_tvalid || led_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("covered %0d items and %0d results: %0d rejected commands,", n_sent,
                 n_checked, n_rejected);
        $display("%0d blink toggles, %0d restores after pulse or pop", n_toggles, n_restores);
        if (n_err == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Generous bound, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/blpc_pkg.sv
hw/rtl/blpc_engine.sv
hw/rtl/blpc_out_fifo.sv
hw/rtl/bicolor_led_blink_pulse_controller.sv
hw/rtl/blpc_checker.sv
tb/sv/testbench.sv
